// ===== rtl/bdci_pkg.sv =====
// Shared types and constants of the block data corruption injector.
// No dependencies; all files of the block but bdci_checker use this package.
`default_nettype none

package bdci_pkg;

  localparam int unsigned PosW  = 64;
  localparam int unsigned LenW  = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned SeedW = 48;
  localparam int unsigned DrawW = 31;
  localparam int unsigned CfgW  = 64;
  localparam int unsigned InW   = PosW + LenW + ByteW;

  localparam logic [31:0]      PAT_KEY       = 32'hDEADBEEF;
  localparam logic [SeedW-1:0] SEED_RESET    = 48'd20017429951246;
  localparam logic [34:0]      LCG_MUL       = 35'h5DEECE66D;
  localparam logic [SeedW-1:0] LCG_INC       = 48'hB;
  // candidates at or above 0xFFFFFF00 are redrawn
  localparam logic [23:0]      REJECT_PREFIX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    MODE_ZERO    = 2'd0,
    MODE_PERSIST = 2'd1,
    MODE_RANDOM  = 2'd2,
    MODE_PASS    = 2'd3
  } bdci_mode_e;

  typedef enum logic [1:0] {
    REG_RANGE_START = 2'd0,
    REG_RANGE_END   = 2'd1,
    REG_MODE        = 2'd2,
    REG_SEED        = 2'd3
  } bdci_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPEN,
    ST_EVAL,
    ST_DRAW,
    ST_EMIT
  } bdci_state_e;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_OFF,
    RS_END,
    RS_SIZE,
    RS_FIT
  } bdci_rstep_e;

  // affected part of the current request
  typedef struct packed {
    logic [LenW-1:0] offset;
    logic [LenW-1:0] length;
    logic [31:0]     base;
    logic            pat_en;
  } bdci_region_t;

endpackage

`default_nettype wire

// ===== rtl/bdci_region.sv =====
// Region sequencer: works out which bytes of a request fall in the disk range.
// One shared 64-bit subtractor over three steps, then a 32-bit fit step; uses bdci_pkg.
`default_nettype none

module bdci_region (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bdci_pkg::PosW-1:0]   pos_i,
  input  wire logic [bdci_pkg::LenW-1:0]   len_i,
  input  wire logic [bdci_pkg::PosW-1:0]   range_start_i,
  input  wire logic [bdci_pkg::PosW-1:0]   range_end_i,
  input  wire bdci_pkg::bdci_mode_e        mode_i,
  output logic                             done_o,
  output bdci_pkg::bdci_region_t           region_o
);

  bdci_pkg::bdci_rstep_e step_q, step_d;

  logic [bdci_pkg::PosW-1:0] pos_q;
  logic [bdci_pkg::LenW-1:0] len_q;
  logic [31:0]               sp_lo_q;
  logic                      pos_gt_q;
  logic                      off_big_q;
  logic                      eof_q;
  logic                      past_end_q;
  logic                      e_small_q;
  logic [31:0]               e_lo_q;
  logic [31:0]               base_q;
  logic [bdci_pkg::LenW-1:0] sz_q;
  bdci_pkg::bdci_region_t    region_q;

  logic [bdci_pkg::PosW-1:0] sub_a;
  logic [bdci_pkg::PosW-1:0] sub_b;
  logic [bdci_pkg::PosW:0]   diff;
  logic [31:0]               off_lo;
  logic                      none;
  logic [bdci_pkg::LenW-1:0] rlen;

  // start minus position, then end minus position, then start minus end
  always_comb begin
    case (step_q)
      bdci_pkg::RS_END: begin
        sub_a = range_end_i;
        sub_b = pos_q;
      end
      bdci_pkg::RS_SIZE: begin
        sub_a = range_start_i;
        sub_b = range_end_i;
      end
      default: begin
        sub_a = range_start_i;
        sub_b = pos_q;
      end
    endcase
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};

  assign off_lo = pos_gt_q ? 32'd0 : sp_lo_q;
  assign none   = (!eof_q && past_end_q) || (!pos_gt_q && off_big_q) || (sz_q <= off_lo);
  assign rlen   = sz_q - off_lo;

  always_comb begin
    step_d = step_q;
    case (step_q)
      bdci_pkg::RS_IDLE: if (start_i) step_d = bdci_pkg::RS_OFF;
      bdci_pkg::RS_OFF:  step_d = bdci_pkg::RS_END;
      bdci_pkg::RS_END:  step_d = bdci_pkg::RS_SIZE;
      bdci_pkg::RS_SIZE: step_d = bdci_pkg::RS_FIT;
      bdci_pkg::RS_FIT:  step_d = bdci_pkg::RS_IDLE;
      default:           step_d = bdci_pkg::RS_IDLE;
    endcase
  end

  always_comb begin
    done_o = (step_q == bdci_pkg::RS_FIT);
  end

  assign region_o = region_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= bdci_pkg::RS_IDLE;
      region_q <= '0;
    end else begin
      step_q <= step_d;
      if (step_q == bdci_pkg::RS_FIT) begin
        region_q.offset <= off_lo;
        region_q.length <= none ? '0 : rlen;
        region_q.base   <= base_q;
        region_q.pat_en <= !none && (mode_i == bdci_pkg::MODE_PERSIST) &&
                           (pos_q[1:0] == 2'b00) && (rlen[1:0] == 2'b00);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (step_q)
      bdci_pkg::RS_IDLE: begin
        if (start_i) begin
          pos_q <= pos_i;
          len_q <= len_i;
        end
      end
      bdci_pkg::RS_OFF: begin
        // borrow here means the request starts past range_start
        pos_gt_q  <= diff[bdci_pkg::PosW];
        sp_lo_q   <= diff[31:0];
        off_big_q <= |diff[bdci_pkg::PosW-1:32];
      end
      bdci_pkg::RS_END: begin
        past_end_q <= diff[bdci_pkg::PosW] || (diff[bdci_pkg::PosW-1:0] == '0);
        e_small_q  <= !diff[bdci_pkg::PosW] && (diff[bdci_pkg::PosW-1:32] == '0);
        e_lo_q     <= diff[31:0];
        base_q     <= pos_gt_q ? (~sp_lo_q + 32'd1) : 32'd0;
      end
      bdci_pkg::RS_SIZE: begin
        // no borrow means start at or past end: range runs to the end of the disk
        eof_q <= !diff[bdci_pkg::PosW];
        // clip the request at a finite range end
        sz_q  <= (!diff[bdci_pkg::PosW] || !e_small_q || (len_q <= e_lo_q)) ? len_q : e_lo_q;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bdci_lcg.sv =====
// 48-bit linear congruential generator built on one shared 24x35 multiplier.
// A draw takes an even and an odd phase, a 32-bit candidate two draws; uses bdci_pkg.
`default_nettype none

module bdci_lcg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic                       seed_we_i,
  input  wire logic [bdci_pkg::SeedW-1:0] seed_i,
  output logic                            done_o,
  output logic [31:0]                     cand_o
);

  logic [bdci_pkg::SeedW-1:0] x_q;
  logic [bdci_pkg::SeedW-1:0] lo_q;
  logic [bdci_pkg::DrawW-1:0] d1_q;
  logic [1:0]                 phase_q;
  logic                       busy_q;

  logic [23:0]                mul_a;
  logic [34:0]                mul_b;
  logic [58:0]                prod;
  logic [bdci_pkg::SeedW-1:0] x_next;

  // even phase: low half times full multiplier; odd phase: high half times low 24 bits
  assign mul_a  = phase_q[0] ? x_q[47:24] : x_q[23:0];
  assign mul_b  = phase_q[0] ? {11'd0, bdci_pkg::LCG_MUL[23:0]} : bdci_pkg::LCG_MUL;
  assign prod   = {35'd0, mul_a} * {24'd0, mul_b};
  assign x_next = lo_q + {prod[23:0], 24'd0} + bdci_pkg::LCG_INC;

  assign done_o = busy_q && (phase_q == 2'd3);
  assign cand_o = {1'b0, d1_q} ^ {x_next[47:17], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q     <= bdci_pkg::SEED_RESET;
      phase_q <= 2'd0;
      busy_q  <= 1'b0;
    end else if (seed_we_i) begin
      x_q <= seed_i;
    end else if (busy_q) begin
      phase_q <= phase_q + 2'd1;
      if (phase_q[0]) x_q <= x_next;
      // a restart at the final phase chains straight into the next candidate
      if (phase_q == 2'd3) busy_q <= start_i;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      phase_q <= 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      if (!phase_q[0]) lo_q <= prod[47:0];
      if (phase_q == 2'd1) d1_q <= x_next[47:17];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/block_data_corruption_injector_core.sv =====
// Top level of the block data corruption injector; instantiates bdci_region and
// bdci_lcg and uses bdci_pkg.
`default_nettype none

// One request byte enters per s_axis transfer and leaves as one m_axis transfer. A byte
// passes the accept, range check and emit states; a request's first byte also waits on
// the region sequencer (a 64-bit subtract per step, then a 32-bit fit). In random mode a
// hit byte waits for a candidate from the shared generator multiplier, and again for each
// rejected one (a 1 in 2^24 event). The output register lets a finished byte wait while
// the next one is taken in. Configuration must be written only while no byte is in
// flight; the block does not enforce it. A seed write reloads the generator at once.
module block_data_corruption_injector_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // request_position [63:0], request_length [95:64], data_in [103:96]
  input  wire logic [bdci_pkg::InW-1:0]    s_axis_tdata,
  input  wire logic                        s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // data_out [7:0]
  output logic [bdci_pkg::ByteW-1:0]       m_axis_tdata,
  output logic                             m_axis_tlast,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_index_i,
  input  wire logic [bdci_pkg::CfgW-1:0]   cfg_data_i
);

  bdci_pkg::bdci_state_e state_q, state_d;

  logic [bdci_pkg::PosW-1:0]  range_start_q;
  logic [bdci_pkg::PosW-1:0]  range_end_q;
  bdci_pkg::bdci_mode_e       mode_q;
  logic [bdci_pkg::LenW-1:0]  idx_q;
  logic [bdci_pkg::ByteW-1:0] data_q;
  logic                       last_q;
  logic [bdci_pkg::LenW-1:0]  k_q;
  logic                       hit_q;
  logic [bdci_pkg::ByteW-1:0] rbyte_q;
  logic                       m_valid_q;
  logic [bdci_pkg::ByteW-1:0] m_data_q;
  logic                       m_last_q;

  logic                       in_fire;
  logic                       region_start;
  logic                       region_done;
  bdci_pkg::bdci_region_t     region;
  logic                       lcg_start;
  logic                       lcg_done;
  logic [31:0]                cand;
  logic                       reject;
  logic                       seed_we;
  logic [bdci_pkg::LenW:0]    kdiff;
  logic                       hit_d;
  logic                       out_free;
  logic                       emit;
  logic [31:0]                pat_word;
  logic [bdci_pkg::ByteW-1:0] pat_byte;
  logic [bdci_pkg::ByteW-1:0] res;

  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign region_start = in_fire && (idx_q == '0);
  assign seed_we      = cfg_we_i && (bdci_pkg::bdci_reg_e'(cfg_index_i) == bdci_pkg::REG_SEED);
  assign reject       = (cand[31:8] == bdci_pkg::REJECT_PREFIX);
  assign out_free     = !m_valid_q || m_axis_tready;

  bdci_region u_region (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (region_start),
    .pos_i         (s_axis_tdata[63:0]),
    .len_i         (s_axis_tdata[95:64]),
    .range_start_i (range_start_q),
    .range_end_i   (range_end_q),
    .mode_i        (mode_q),
    .done_o        (region_done),
    .region_o      (region)
  );

  bdci_lcg u_lcg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (lcg_start),
    .seed_we_i (seed_we),
    .seed_i    (cfg_data_i[bdci_pkg::SeedW-1:0]),
    .done_o    (lcg_done),
    .cand_o    (cand)
  );

  // position of this byte inside the affected region
  assign kdiff = {1'b0, idx_q} - {1'b0, region.offset};
  assign hit_d = (region.length != '0) && !kdiff[bdci_pkg::LenW] &&
                 (kdiff[bdci_pkg::LenW-1:0] < region.length);

  assign pat_word = (region.base + {k_q[31:2], 2'b00}) ^ bdci_pkg::PAT_KEY;

  always_comb begin
    case (k_q[1:0])
      2'd0:    pat_byte = pat_word[7:0];
      2'd1:    pat_byte = pat_word[15:8];
      2'd2:    pat_byte = pat_word[23:16];
      default: pat_byte = pat_word[31:24];
    endcase
  end

  always_comb begin
    res = data_q;
    if (hit_q) begin
      case (mode_q)
        bdci_pkg::MODE_ZERO:    res = '0;
        bdci_pkg::MODE_PERSIST: if (region.pat_en) res = pat_byte;
        bdci_pkg::MODE_RANDOM:  res = rbyte_q;
        default:                res = data_q;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bdci_pkg::ST_IDLE: begin
        if (in_fire) state_d = (idx_q == '0) ? bdci_pkg::ST_OPEN : bdci_pkg::ST_EVAL;
      end
      bdci_pkg::ST_OPEN: if (region_done) state_d = bdci_pkg::ST_EVAL;
      bdci_pkg::ST_EVAL: begin
        state_d = (hit_d && (mode_q == bdci_pkg::MODE_RANDOM)) ?
                  bdci_pkg::ST_DRAW : bdci_pkg::ST_EMIT;
      end
      bdci_pkg::ST_DRAW: if (lcg_done && !reject) state_d = bdci_pkg::ST_EMIT;
      bdci_pkg::ST_EMIT: if (out_free) state_d = bdci_pkg::ST_IDLE;
      default:           state_d = bdci_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    lcg_start     = 1'b0;
    emit          = 1'b0;
    case (state_q)
      bdci_pkg::ST_IDLE: s_axis_tready = 1'b1;
      bdci_pkg::ST_EVAL: lcg_start = hit_d && (mode_q == bdci_pkg::MODE_RANDOM);
      bdci_pkg::ST_DRAW: lcg_start = lcg_done && reject;
      bdci_pkg::ST_EMIT: emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= bdci_pkg::ST_IDLE;
      range_start_q <= '0;
      range_end_q   <= '0;
      mode_q        <= bdci_pkg::MODE_PASS;
      idx_q         <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (bdci_pkg::bdci_reg_e'(cfg_index_i))
          bdci_pkg::REG_RANGE_START: range_start_q <= cfg_data_i;
          bdci_pkg::REG_RANGE_END:   range_end_q   <= cfg_data_i;
          bdci_pkg::REG_MODE:        mode_q <= bdci_pkg::bdci_mode_e'(cfg_data_i[1:0]);
          default: ;
        endcase
      end
      if (emit) begin
        idx_q     <= last_q ? '0 : idx_q + 32'd1;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q <= s_axis_tdata[103:96];
      last_q <= s_axis_tlast;
    end
    if (state_q == bdci_pkg::ST_EVAL) begin
      k_q   <= kdiff[bdci_pkg::LenW-1:0];
      hit_q <= hit_d;
    end
    if (lcg_done) rbyte_q <= cand[7:0];
    if (emit) begin
      m_data_q <= res;
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

// ===== rtl/bdci_checker.sv =====
// Port-level checker for block_data_corruption_injector_core, bound to the top level.
// Sees only the top-level ports; no package dependency.
`default_nettype none

module bdci_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("m_axis result changed while stalled");

  // after its transfer, ready stays low while the byte is range-checked and moved on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken again too early");

  // ready drops only because a byte was taken
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("ready dropped without a transfer");

  // the block frees up only as it hands a byte to the output register
  a_ready_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> m_axis_tvalid)
    else $error("ready returned without a result");

endmodule

bind block_data_corruption_injector_core bdci_checker u_bdci_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== test/block_data_corruption_injector_core_tb.sv =====
// Self-checking bench for block_data_corruption_injector_core: streams request bytes
// with random bursts and output stalls, and predicts every output byte on its own.
// Depends on bdci_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module block_data_corruption_injector_core_tb;

  localparam logic [31:0] SCRAMBLE_WORD = 32'hDEADBEEF;
  localparam logic [47:0] SEED_AT_RESET = 48'd20017429951246;
  localparam logic [63:0] DISK_END      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          TARGET_BYTES  = 1574;
  localparam int          SETTLE_CYCLES = 32;
  localparam int          MAX_REPORTS   = 20;

  typedef struct packed {
    logic [63:0] pos;
    logic [31:0] len;
    logic [7:0]  data;
    logic        last;
  } req_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [7:0] raw;
  } out_byte_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [bdci_pkg::InW-1:0]      s_axis_tdata  = '0;
  logic                          s_axis_tlast  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [bdci_pkg::ByteW-1:0]    m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          cfg_we_i      = 1'b0;
  logic [1:0]                    cfg_index_i   = bdci_pkg::REG_RANGE_START;
  logic [bdci_pkg::CfgW-1:0]     cfg_data_i    = '0;

  // predictor copy of the registers and the per-request state
  logic [63:0]          lim_lo   = '0;
  logic [63:0]          lim_hi   = '0;
  bdci_pkg::bdci_mode_e cur_mode = bdci_pkg::MODE_PASS;
  logic [47:0]          lcg_x    = SEED_AT_RESET;
  logic [31:0]          req_idx  = '0;
  logic [31:0]          win_off  = '0;
  logic [31:0]          win_len  = '0;
  logic [31:0]          pat_base = '0;
  logic                 pat_ok   = 1'b0;

  req_byte_t req_bytes_q[$];
  out_byte_t due_bytes_q[$];
  req_byte_t cur_byte;

  int burst_left = 0;
  int gap_left   = 0;
  int stall_left = 0;
  logic [15:0] stall_pat = '1;

  int n_queued  = 0;
  int n_checked = 0;
  int n_altered = 0;
  int n_writes  = 0;
  int n_errors  = 0;

  block_data_corruption_injector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] lcg_draw();
    lcg_x = lcg_x * 48'h5DEECE66D + 48'hB;
    return {1'b0, lcg_x[47:17]};
  endfunction

  function automatic logic [31:0] lcg_candidate();
    logic [31:0] a, b;
    a = lcg_draw();
    b = lcg_draw();
    return a ^ (b << 1);
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [31:0] c;
    c = lcg_candidate();
    // redraw from the top 256 values so the byte stays uniform
    while (c >= 32'hFFFFFF00) c = lcg_candidate();
    return c[7:0];
  endfunction

  // work out which part of the request falls in the range, at its first byte
  function automatic void open_window(logic [63:0] pos, logic [31:0] size);
    logic [63:0] skip, off, sz, d;
    logic        to_eof;
    to_eof   = lim_lo >= lim_hi;
    win_off  = '0;
    win_len  = '0;
    pat_base = '0;
    pat_ok   = 1'b0;
    sz       = {32'd0, size};
    if (pos > lim_lo) begin
      skip = pos - lim_lo;
      off  = '0;
    end else begin
      skip = '0;
      off  = lim_lo - pos;
    end
    if (!to_eof) begin
      if (pos >= lim_hi) return;
      d = lim_hi - pos;
      if (d < sz) sz = d;
    end
    if (sz <= off) return;
    win_off  = off[31:0];
    win_len  = sz[31:0] - off[31:0];
    pat_base = skip[31:0];
    pat_ok   = cur_mode == bdci_pkg::MODE_PERSIST && pos[1:0] == 2'b00 &&
               win_len[1:0] == 2'b00;
  endfunction

  function automatic logic [7:0] corrupted_byte(req_byte_t b);
    logic [31:0] k, w;
    logic [7:0]  res;
    res = b.data;
    if (req_idx == 0) open_window(b.pos, b.len);
    if (win_len != 0 && req_idx >= win_off && req_idx - win_off < win_len) begin
      k = req_idx - win_off;
      case (cur_mode)
        bdci_pkg::MODE_ZERO: res = '0;
        bdci_pkg::MODE_PERSIST: begin
          if (pat_ok) begin
            w   = (pat_base + {k[31:2], 2'b00}) ^ SCRAMBLE_WORD;
            res = w[8*k[1:0] +: 8];
          end
        end
        bdci_pkg::MODE_RANDOM: res = rand_byte();
        default: ;
      endcase
    end
    req_idx = b.last ? 32'd0 : req_idx + 32'd1;
    return res;
  endfunction

  // sender: bursts of transfers with random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin : send_proc
    logic fire;
    logic hold;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) due_bytes_q.push_back({corrupted_byte(cur_byte), cur_byte.last, cur_byte.data});
      hold = s_axis_tvalid && !fire;
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_bytes_q.size() > 0) begin
          cur_byte = req_bytes_q.pop_front();
          hold = 1'b1;
          s_axis_tdata <= {cur_byte.data, cur_byte.len, cur_byte.pos};
          s_axis_tlast <= cur_byte.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      s_axis_tvalid <= hold;
    end
  end

  // receiver: ready follows a rotating pattern that is redrawn now and then
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_pat     <= '1;
      stall_left    <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_left <= $urandom_range(16, 160);
        case ($urandom_range(0, 3))
          0:       stall_pat <= '1;
          1:       stall_pat <= 16'($urandom) | 16'h0001;
          2:       stall_pat <= 16'($urandom & $urandom) | 16'h0001;
          default: stall_pat <= 16'($urandom) | 16'h0101;
        endcase
      end else begin
        stall_left <= stall_left - 1;
        stall_pat  <= {stall_pat[0], stall_pat[15:1]};
      end
      m_axis_tready <= stall_pat[0];
    end
  end

  task automatic flag_error(string what, logic [7:0] exp_v, logic [7:0] act_v);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("%0t %s mismatch: expected %02h actual %02h", $time, what, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin : check_proc
    out_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_bytes_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t unexpected transfer: expected none actual %02h", $time, m_axis_tdata);
      end else begin
        want = due_bytes_q.pop_front();
        if (m_axis_tdata !== want.data) flag_error("data_out", want.data, m_axis_tdata);
        if (m_axis_tlast !== want.last)
          flag_error("last_out", {7'd0, want.last}, {7'd0, m_axis_tlast});
        n_checked++;
        if (want.data != want.raw) n_altered++;
      end
    end
  end

  task automatic write_reg(input bdci_pkg::bdci_reg_e idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bdci_pkg::REG_RANGE_START: lim_lo = val;
      bdci_pkg::REG_RANGE_END:   lim_hi = val;
      bdci_pkg::REG_MODE:        cur_mode = bdci_pkg::bdci_mode_e'(val[1:0]);
      default:                   lcg_x = val[47:0];
    endcase
    n_writes++;
  endtask

  task automatic push_request(input logic [63:0] pos, input logic [31:0] lenf, input int n,
                              input bit close);
    req_byte_t b;
    for (int i = 0; i < n; i++) begin
      b.pos  = pos;
      b.len  = lenf;
      b.data = 8'($urandom_range(0, 255));
      b.last = close && (i == n - 1);
      req_bytes_q.push_back(b);
    end
    n_queued += n;
  endtask

  // wait until every byte went through and the block has settled
  task automatic drain();
    while (req_bytes_q.size() > 0 || s_axis_tvalid || due_bytes_q.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase();
    logic [63:0] anchor, lo, hi, pos;
    logic [31:0] lenf;
    int          n, reqs;
    bit          align;
    drain();
    anchor = {$urandom, $urandom};
    align  = ($urandom_range(0, 1) != 0);
    if (align) anchor[1:0] = 2'b00;
    case ($urandom_range(0, 5))
      0: begin lo = '0; hi = '0; end
      1: begin lo = anchor; hi = anchor + 64'($urandom_range(1, 48)); end
      2: begin lo = anchor; hi = $urandom_range(0, 1) ? anchor : 64'd0; end
      3: begin lo = DISK_END - 64'($urandom_range(0, 40)); hi = DISK_END; end
      4: begin lo = anchor; hi = DISK_END; end
      default: begin lo = anchor + 64'd100; hi = anchor; end
    endcase
    write_reg(bdci_pkg::REG_RANGE_START, lo);
    write_reg(bdci_pkg::REG_RANGE_END, hi);
    write_reg(bdci_pkg::REG_MODE,
              64'($urandom_range(bdci_pkg::MODE_ZERO, bdci_pkg::MODE_PASS)));
    case ($urandom_range(0, 5))
      0: write_reg(bdci_pkg::REG_SEED, {$urandom, $urandom});
      1: write_reg(bdci_pkg::REG_SEED, 64'd0);
      2: write_reg(bdci_pkg::REG_SEED, 64'hFFFF_FFFF_FFFF);
      default: ;
    endcase
    reqs = $urandom_range(3, 10);
    for (int r = 0; r < reqs; r++) begin
      n = $urandom_range(0, 1) ? 4 * $urandom_range(1, 6) : $urandom_range(1, 24);
      case ($urandom_range(0, 4))
        0: pos = anchor + 64'($urandom_range(0, 40)) - 64'd20;
        1: pos = lo - 64'(n) + 64'($urandom_range(0, 8));
        2: pos = hi - 64'($urandom_range(0, 30));
        3: pos = {$urandom, $urandom};
        default: pos = DISK_END - 64'($urandom_range(0, 40));
      endcase
      if (align && $urandom_range(0, 3) != 0) pos[1:0] = 2'b00;
      case ($urandom_range(0, 7))
        0: lenf = $urandom_range(1, n);
        1: begin
          lenf = $urandom;
          if (lenf == 0) lenf = 32'd1;
        end
        2: lenf = 32'hFFFF_FFFF;
        default: lenf = n;
      endcase
      // now and then leave the last request open across the next register writes
      push_request(pos, lenf, n, !(r == reqs - 1 && $urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings pass everything through
    push_request(64'd0, 32'd2, 2, 1'b1);

    // zero fill: partial overlap at the start, then a request at the range end
    drain();
    write_reg(bdci_pkg::REG_RANGE_START, 64'd100);
    write_reg(bdci_pkg::REG_RANGE_END, 64'd200);
    write_reg(bdci_pkg::REG_MODE, 64'(bdci_pkg::MODE_ZERO));
    push_request(64'd98, 32'd4, 4, 1'b1);
    push_request(64'd200, 32'd2, 2, 1'b1);

    // persistent pattern up to the end of the disk, aligned then misaligned
    drain();
    write_reg(bdci_pkg::REG_RANGE_START, 64'd64);
    write_reg(bdci_pkg::REG_RANGE_END, 64'd0);
    write_reg(bdci_pkg::REG_MODE, 64'(bdci_pkg::MODE_PERSIST));
    push_request(64'd60, 32'd8, 8, 1'b1);
    push_request(64'd66, 32'd2, 2, 1'b1);

    // random bytes at the very last disk position with the longest length
    drain();
    write_reg(bdci_pkg::REG_RANGE_START, DISK_END);
    write_reg(bdci_pkg::REG_MODE, 64'(bdci_pkg::MODE_RANDOM));
    push_request(DISK_END, 32'hFFFF_FFFF, 2, 1'b1);

    // switch mode and reseed in the middle of a request
    drain();
    write_reg(bdci_pkg::REG_RANGE_START, 64'd0);
    write_reg(bdci_pkg::REG_MODE, 64'(bdci_pkg::MODE_ZERO));
    push_request(64'd5, 32'd4, 2, 1'b0);
    drain();
    write_reg(bdci_pkg::REG_MODE, 64'(bdci_pkg::MODE_RANDOM));
    write_reg(bdci_pkg::REG_SEED, 64'hFFFF_FFFF_FFFF);
    push_request(64'd0, 32'd1, 2, 1'b1);

    while (n_queued < TARGET_BYTES) random_phase();
    drain();

    $display("streamed %0d request bytes over %0d register writes, %0d outputs checked",
             n_queued, n_writes, n_checked);
    $display("%0d bytes were altered in flight, %0d mismatches seen", n_altered, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d outputs still due", due_bytes_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== block_data_corruption_injector_core.f =====
rtl/bdci_pkg.sv
rtl/bdci_region.sv
rtl/bdci_lcg.sv
rtl/block_data_corruption_injector_core.sv
rtl/bdci_checker.sv
test/block_data_corruption_injector_core_tb.sv
